FILE: design/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
// Depends on nothing; used by the interfaces and the top-level module.
package stq_pkg;

  localparam int DEPTH_DEF   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int ID_W        = 8;
  localparam int KIND_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_FIRED  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [ID_W-1:0]   id;
  } entry_t;

  // a strictly after b, wrap-safe
  function automatic logic is_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

FILE: design/stq_if.sv
// Valid/ready channel interfaces for the timer queue input and result words.
// Depends on stq_pkg.
interface stq_in_if;
  import stq_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [DELAY_W-1:0] delay;
  logic [ID_W-1:0]    timer_id;

  modport source(output valid, mode, delay, timer_id, input ready);
  modport sink(input valid, mode, delay, timer_id, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   fired_id;
  logic [TIME_W-1:0] due_time;
  logic              last;

  modport source(output valid, kind, fired_id, due_time, last, input ready);
  modport sink(input valid, kind, fired_id, due_time, last, output ready);
endinterface

FILE: design/stq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sorted_timer_queue.sv
// Top level of the sorted timer queue: sequencer, time counter and result staging.
// Depends on stq_pkg, stq_in_if, stq_out_if and stq_ram.
//
// Usage: in_i takes words with mode (0 set a timer, 1 one tick), delay and
// timer_id. out_o returns result words: accepted, full, or fired, with
// last set on the final word caused by an input word.
// Timers live in one RAM as a circular list sorted by due time. A set word
// scans forward from the oldest entry, then moves the later entries up one
// slot and writes the new one. Firing reads the oldest entry. One input word
// is processed at a time; in_i.ready is high only between words. Each RAM
// step is a read state followed by a wait state, since the RAM read data is
// registered.
// Each result waits in a staging register until the next entry is checked,
// so last can be set; a stalled out_o holds the sequencer at that point,
// while the word already in the output register stays stable.
// Reset clears the time counter, the list head and the entry count; the RAM
// needs no clearing since only occupied slots are read.
module sorted_timer_queue #(
  parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stq_in_if.sink    in_i,
  stq_out_if.source out_o
);
  import stq_pkg::*;

  localparam int SW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = $clog2(MAX_RESULTS + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [KW-1:0] MAX_K = KW'(MAX_RESULTS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH     = 3'd1;
  localparam logic [2:0] S_SRCH_W   = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_SHIFT_W  = 3'd4;
  localparam logic [2:0] S_FIRE_RD  = 3'd5;
  localparam logic [2:0] S_FIRE_CHK = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head, input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW + 1)'(head) + (CW + 1)'(pos);
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[SW-1:0];
  endfunction

  logic [2:0]        state_q, state_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [SW-1:0]     oldest_q, oldest_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     p_q, p_d;
  logic [KW-1:0]     k_q, k_d;
  logic [TIME_W-1:0] new_due_q, new_due_d;
  logic [ID_W-1:0]   new_id_q, new_id_d;

  logic              hold_valid_q, hold_valid_d;
  kind_e             hold_kind_q, hold_kind_d;
  logic [ID_W-1:0]   hold_id_q, hold_id_d;
  logic [TIME_W-1:0] hold_due_q, hold_due_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [TIME_W-1:0] out_due_q, out_due_d;
  logic              out_last_q, out_last_d;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic          out_free;

  stq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.fired_id = out_id_q;
  assign out_o.due_time = out_due_q;
  assign out_o.last     = out_last_q;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    oldest_d     = oldest_q;
    count_d      = count_q;
    pos_d        = pos_q;
    p_d          = p_q;
    k_d          = k_q;
    new_due_d    = new_due_q;
    new_id_d     = new_id_q;
    hold_valid_d = hold_valid_q;
    hold_kind_d  = hold_kind_q;
    hold_id_d    = hold_id_q;
    hold_due_d   = hold_due_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_due_d    = out_due_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = slot_of(oldest_q, p_q);
    ram_raddr    = oldest_q;
    ram_wdata    = ram_rdata;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          k_d = '0;
          if (in_i.mode) begin
            now_d   = now_q + 1'b1;
            state_d = S_FIRE_RD;
          end else begin
            new_due_d = now_q + TIME_W'(in_i.delay);
            new_id_d  = in_i.timer_id;
            if (count_q == FULL_CNT) begin
              hold_valid_d = 1'b1;
              hold_kind_d  = KIND_FULL;
              hold_id_d    = '0;
              hold_due_d   = '0;
              state_d      = S_FINISH;
            end else begin
              pos_d   = '0;
              state_d = S_SRCH;
            end
          end
        end
      end
      S_SRCH: begin
        if (pos_q == count_q) begin
          p_d     = count_q;
          state_d = S_SHIFT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(oldest_q, pos_q);
          state_d   = S_SRCH_W;
        end
      end
      S_SRCH_W: begin
        if (is_after(ram_rdata.due, new_due_q)) begin
          p_d     = count_q;
          state_d = S_SHIFT;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = S_SRCH;
        end
      end
      S_SHIFT: begin
        if (p_q == pos_q) begin
          ram_we        = 1'b1;
          ram_waddr     = slot_of(oldest_q, pos_q);
          ram_wdata.due = new_due_q;
          ram_wdata.id  = new_id_q;
          count_d       = count_q + 1'b1;
          hold_valid_d  = 1'b1;
          hold_kind_d   = KIND_ACCEPT;
          hold_id_d     = '0;
          hold_due_d    = new_due_q;
          k_d           = KW'(1);
          state_d       = S_FIRE_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(oldest_q, p_q - 1'b1);
          state_d   = S_SHIFT_W;
        end
      end
      S_SHIFT_W: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(oldest_q, p_q);
        p_d       = p_q - 1'b1;
        state_d   = S_SHIFT;
      end
      S_FIRE_RD: begin
        if (count_q == '0 || k_q == MAX_K) begin
          state_d = S_FINISH;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = oldest_q;
          state_d   = S_FIRE_CHK;
        end
      end
      S_FIRE_CHK: begin
        if (is_after(ram_rdata.due, now_q)) begin
          state_d = S_FINISH;
        end else if (!hold_valid_q || out_free) begin
          if (hold_valid_q) begin
            out_valid_d = 1'b1;
            out_kind_d  = hold_kind_q;
            out_id_d    = hold_id_q;
            out_due_d   = hold_due_q;
            out_last_d  = 1'b0;
          end
          hold_valid_d = 1'b1;
          hold_kind_d  = KIND_FIRED;
          hold_id_d    = ram_rdata.id;
          hold_due_d   = ram_rdata.due;
          oldest_d     = (oldest_q == SW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
          count_d      = count_q - 1'b1;
          k_d          = k_q + 1'b1;
          state_d      = S_FIRE_RD;
        end
      end
      S_FINISH: begin
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = hold_kind_q;
          out_id_d     = hold_id_q;
          out_due_d    = hold_due_q;
          out_last_d   = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      now_q        <= '0;
      oldest_q     <= '0;
      count_q      <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      oldest_q     <= oldest_d;
      count_q      <= count_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    p_q         <= p_d;
    k_q         <= k_d;
    new_due_q   <= new_due_d;
    new_id_q    <= new_id_d;
    hold_kind_q <= hold_kind_d;
    hold_id_q   <= hold_id_d;
    hold_due_q  <= hold_due_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_due_q   <= out_due_d;
    out_last_q  <= out_last_d;
  end

endmodule
